>>> rtl/core/wsms_pkg.sv
// ----------------------------------------------------------------------------
// wsms_pkg: shared types and constants
// Datapath operation codes, status bundle and the power-of-three table.
// ----------------------------------------------------------------------------
package wsms_pkg;

    localparam int DATA_W     = 32;
    localparam int POW3_DEPTH = 20;
    localparam int PW_W       = 5;

    localparam logic [DATA_W-1:0] POW3_TAB [POW3_DEPTH] = '{
        32'd1, 32'd3, 32'd9, 32'd27, 32'd81, 32'd243, 32'd729, 32'd2187,
        32'd6561, 32'd19683, 32'd59049, 32'd177147, 32'd531441, 32'd1594323,
        32'd4782969, 32'd14348907, 32'd43046721, 32'd129140163,
        32'd387420489, 32'd1162261467
    };

    // 3**idx, saturated past the table
    function automatic logic [DATA_W-1:0] pow3_at(input logic [PW_W-1:0] idx);
        logic [DATA_W-1:0] res;
        if (int'(idx) < POW3_DEPTH) begin
            res = POW3_TAB[idx];
        end else begin
            res = '1;
        end
        return res;
    endfunction

    typedef enum logic [5:0] {
        OP_NONE, OP_LOAD, OP_SEL_INIT, OP_PIV_RD, OP_PIV_CAP, OP_V_RD,
        OP_EQ_STEP, OP_LT_SET, OP_GT_SET, OP_LT_POST, OP_GT_POST, OP_NARROW,
        OP_SW_RA, OP_SW_RB, OP_SW_WA, OP_SW_WB, OP_REV_STEP,
        OP_SH_INIT, OP_PW_INC, OP_PW_DEC, OP_REV1_SET, OP_REV2_SET, OP_REV3_SET,
        OP_CY_INIT, OP_CY_RD0, OP_CY_CAP, OP_CY_RD, OP_CY_XCH, OP_CY_CLOSE,
        OP_SH_ADV, OP_FREV_SET, OP_EM_INIT, OP_EM_RD, OP_EM_CAP, OP_EM_NEXT,
        OP_EM_DONE
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } wsms_cmd_t;

    typedef struct packed {
        logic part_done;
        logic v_eq;
        logic v_lt;
        logic sel_hit;
        logic sel_live;
        logic rev_live;
        logic even;
        logic size_more;
        logic sh_live;
        logic split_fit;
        logic cy_closed;
        logic cy_more;
        logic em_last;
    } wsms_stat_t;

endpackage

>>> rtl/core/wsms_datapath.sv
// ----------------------------------------------------------------------------
// wsms_datapath: value store and index registers
// Executes one operation code per cycle; one read and one write port.
// ----------------------------------------------------------------------------
module wsms_datapath import wsms_pkg::*; #(
    parameter int MAX_N            = 64,
    parameter int POW3_TABLE_DEPTH = 20
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  wsms_cmd_t                cmd,
    input  logic signed [DATA_W-1:0] s_value,
    output wsms_stat_t               stat,
    output logic signed [DATA_W-1:0] m_result_value,
    output logic                     m_final_res,
    output logic                     m_overflowed,
    output logic                     m_valid
);

    localparam int AW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
    localparam int CW = $clog2(MAX_N + 1);
    localparam int IW = CW + 2;
    localparam logic signed [IW-1:0] ONE = IW'(1);

    typedef logic signed [IW-1:0] idx_t;

    logic signed [DATA_W-1:0] mem [MAX_N];
    logic signed [DATA_W-1:0] rd_reg;

    idx_t l_reg, l_next, r_reg, r_next, lo_reg, lo_next, hi_reg, hi_next;
    idx_t i_reg, i_next, a_reg, a_next, b_reg, b_next;
    idx_t cur_reg, cur_next, init_reg, init_next;
    idx_t sl_reg, sl_next, sr_reg, sr_next, sn_reg, sn_next;
    logic signed [DATA_W-1:0] piv_reg, piv_next, ta_reg, ta_next;
    logic signed [DATA_W-1:0] carry_reg, carry_next, res_reg, res_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            ovf_reg, ovf_next, fin_reg, fin_next;
    logic            oflag_reg, oflag_next, mval_reg, mval_next;
    logic [PW_W-1:0] pw_reg, pw_next, j_reg, j_next;
    logic [AW-1:0]   k_reg, k_next;

    idx_t rd_addr, wr_addr, kk, mid_sh, sp, hsp, cy_r, init_addr;
    logic signed [DATA_W-1:0] wr_data;
    logic                     wr_en;
    logic [DATA_W-1:0]        sn32;

    function automatic idx_t dest_of(input idx_t x, input idx_t lb, input idx_t rb);
        idx_t mid;
        mid = (lb + rb) >>> 1;
        if (x <= mid) begin
            return x + x - lb + ONE;
        end
        return x + x - rb - ONE;
    endfunction

    assign kk        = idx_t'(cnt_reg >> 1);
    assign mid_sh    = (sl_reg + sr_reg) >>> 1;
    assign sp        = idx_t'(pow3_at(pw_reg)) - ONE;
    assign hsp       = sp >>> 1;
    assign cy_r      = sl_reg + sp - ONE;
    assign init_addr = sl_reg + idx_t'(pow3_at(j_reg - PW_W'(1))) - ONE;
    assign sn32      = DATA_W'(unsigned'(sn_reg));

    always_comb begin
        stat.part_done = i_reg > hi_reg;
        stat.v_eq      = rd_reg == piv_reg;
        stat.v_lt      = rd_reg < piv_reg;
        stat.sel_hit   = !(kk < lo_reg) && !(kk > hi_reg);
        stat.sel_live  = l_reg <= r_reg;
        stat.rev_live  = a_reg < b_reg;
        stat.even      = !cnt_reg[0];
        stat.size_more = (int'(pw_reg) < POW3_TABLE_DEPTH - 1) &&
                         (pow3_at(pw_reg + PW_W'(1)) - DATA_W'(1) <= sn32);
        stat.sh_live   = (sn_reg > idx_t'(0)) && (pw_reg != '0);
        stat.split_fit = pow3_at(pw_reg) - DATA_W'(1) <= sn32;
        stat.cy_closed = cur_reg == init_reg;
        stat.cy_more   = j_reg <= pw_reg;
        stat.em_last   = CW'(k_reg) == cnt_reg - CW'(1);
    end

    always_comb begin
        l_next = l_reg;     r_next = r_reg;     lo_next = lo_reg;   hi_next = hi_reg;
        i_next = i_reg;     a_next = a_reg;     b_next = b_reg;
        cur_next = cur_reg; init_next = init_reg;
        sl_next = sl_reg;   sr_next = sr_reg;   sn_next = sn_reg;
        piv_next = piv_reg; ta_next = ta_reg;   carry_next = carry_reg;
        res_next = res_reg; fin_next = fin_reg; oflag_next = oflag_reg;
        mval_next = mval_reg;
        cnt_next = cnt_reg; ovf_next = ovf_reg;
        pw_next = pw_reg;   j_next = j_reg;     k_next = k_reg;
        rd_addr = '0;
        wr_addr = '0;
        wr_data = carry_reg;
        wr_en   = 1'b0;
        unique case (cmd.op)
            OP_LOAD: begin
                if (int'(cnt_reg) < MAX_N) begin
                    wr_en    = 1'b1;
                    wr_addr  = idx_t'(cnt_reg);
                    wr_data  = s_value;
                    cnt_next = cnt_reg + CW'(1);
                end else begin
                    ovf_next = 1'b1;
                end
            end
            OP_SEL_INIT: begin
                l_next = '0;
                r_next = idx_t'(cnt_reg) - ONE;
            end
            OP_PIV_RD: begin
                rd_addr = l_reg + ((r_reg - l_reg) >>> 1);
                lo_next = l_reg;
                hi_next = r_reg;
                i_next  = l_reg;
            end
            OP_PIV_CAP:  piv_next = rd_reg;
            OP_V_RD:     rd_addr = i_reg;
            OP_EQ_STEP:  i_next = i_reg + ONE;
            OP_LT_SET: begin
                a_next = lo_reg;
                b_next = i_reg;
            end
            OP_GT_SET: begin
                a_next = i_reg;
                b_next = hi_reg;
            end
            OP_LT_POST: begin
                lo_next = lo_reg + ONE;
                i_next  = i_reg + ONE;
            end
            OP_GT_POST:  hi_next = hi_reg - ONE;
            OP_NARROW: begin
                if (kk < lo_reg) begin
                    r_next = lo_reg - ONE;
                end else if (kk > hi_reg) begin
                    l_next = hi_reg + ONE;
                end
            end
            OP_SW_RA:    rd_addr = a_reg;
            OP_SW_RB: begin
                rd_addr = b_reg;
                ta_next = rd_reg;
            end
            OP_SW_WA: begin
                wr_en   = 1'b1;
                wr_addr = a_reg;
                wr_data = rd_reg;
            end
            OP_SW_WB: begin
                wr_en   = 1'b1;
                wr_addr = b_reg;
                wr_data = ta_reg;
            end
            OP_REV_STEP: begin
                a_next = a_reg + ONE;
                b_next = b_reg - ONE;
            end
            OP_SH_INIT: begin
                sl_next = cnt_reg[0] ? ONE : idx_t'(0);
                sr_next = idx_t'(cnt_reg) - ONE;
                sn_next = cnt_reg[0] ? idx_t'(cnt_reg) - ONE : idx_t'(cnt_reg);
                pw_next = '0;
            end
            OP_PW_INC:   pw_next = pw_reg + PW_W'(1);
            OP_PW_DEC:   pw_next = pw_reg - PW_W'(1);
            OP_REV1_SET: begin
                a_next = sl_reg + hsp;
                b_next = mid_sh;
            end
            OP_REV2_SET: begin
                a_next = mid_sh + ONE;
                b_next = mid_sh + hsp;
            end
            OP_REV3_SET: begin
                a_next = sl_reg + hsp;
                b_next = mid_sh + hsp;
            end
            OP_CY_INIT:  j_next = PW_W'(1);
            OP_CY_RD0: begin
                rd_addr   = init_addr;
                init_next = init_addr;
            end
            OP_CY_CAP: begin
                carry_next = rd_reg;
                cur_next   = dest_of(init_reg, sl_reg, cy_r);
            end
            OP_CY_RD:    rd_addr = cur_reg;
            OP_CY_XCH: begin
                wr_en      = 1'b1;
                wr_addr    = cur_reg;
                carry_next = rd_reg;
                cur_next   = dest_of(cur_reg, sl_reg, cy_r);
            end
            OP_CY_CLOSE: begin
                wr_en   = 1'b1;
                wr_addr = init_reg;
                j_next  = j_reg + PW_W'(1);
            end
            OP_SH_ADV: begin
                sl_next = sl_reg + sp;
                sn_next = sn_reg - sp;
            end
            OP_FREV_SET: begin
                a_next = '0;
                b_next = idx_t'(cnt_reg) - ONE;
            end
            OP_EM_INIT:  k_next = '0;
            OP_EM_RD:    rd_addr = idx_t'(k_reg);
            OP_EM_CAP: begin
                res_next   = rd_reg;
                fin_next   = stat.em_last;
                oflag_next = ovf_reg;
                mval_next  = 1'b1;
            end
            OP_EM_NEXT: begin
                mval_next = 1'b0;
                k_next    = k_reg + AW'(1);
            end
            OP_EM_DONE: begin
                mval_next = 1'b0;
                cnt_next  = '0;
                ovf_next  = 1'b0;
            end
            default: ;
        endcase
    end

    // value store, registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr[AW-1:0]] <= wr_data;
        end
        rd_reg <= mem[rd_addr[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            ovf_reg  <= 1'b0;
            mval_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            ovf_reg  <= ovf_next;
            mval_reg <= mval_next;
        end
    end

    always_ff @(posedge aclk) begin
        l_reg <= l_next;       r_reg <= r_next;       lo_reg <= lo_next;
        hi_reg <= hi_next;     i_reg <= i_next;       a_reg <= a_next;
        b_reg <= b_next;       cur_reg <= cur_next;   init_reg <= init_next;
        sl_reg <= sl_next;     sr_reg <= sr_next;     sn_reg <= sn_next;
        piv_reg <= piv_next;   ta_reg <= ta_next;     carry_reg <= carry_next;
        res_reg <= res_next;   fin_reg <= fin_next;   oflag_reg <= oflag_next;
        pw_reg <= pw_next;     j_reg <= j_next;       k_reg <= k_next;
    end

    assign m_result_value = res_reg;
    assign m_final_res    = fin_reg;
    assign m_overflowed   = oflag_reg;
    assign m_valid        = mval_reg;

endmodule

>>> rtl/core/wsms_ctrl.sv
// ----------------------------------------------------------------------------
// wsms_ctrl: sequencing state machine
// Steps load, selection, shuffle, reversal and emit; issues datapath ops.
// ----------------------------------------------------------------------------
module wsms_ctrl import wsms_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_last,
    input  logic       m_ready,
    input  wsms_stat_t stat,
    output wsms_cmd_t  cmd,
    output logic       s_ready
);

    typedef enum logic [32:0] {
        S_LOAD     = 33'h1 << 0,  S_SEL_INIT = 33'h1 << 1,  S_SEL_CHK  = 33'h1 << 2,
        S_PIV_RD   = 33'h1 << 3,  S_PIV_CAP  = 33'h1 << 4,  S_PART     = 33'h1 << 5,
        S_V_DEC    = 33'h1 << 6,  S_LT_POST  = 33'h1 << 7,  S_GT_POST  = 33'h1 << 8,
        S_NARROW   = 33'h1 << 9,  S_SW_RA    = 33'h1 << 10, S_SW_RB    = 33'h1 << 11,
        S_SW_WA    = 33'h1 << 12, S_SW_WB    = 33'h1 << 13, S_REV      = 33'h1 << 14,
        S_REV_STEP = 33'h1 << 15, S_SH_INIT  = 33'h1 << 16, S_SH_SIZE  = 33'h1 << 17,
        S_SH_LOOP  = 33'h1 << 18, S_REV2     = 33'h1 << 19, S_REV3     = 33'h1 << 20,
        S_CY_INIT  = 33'h1 << 21, S_CY_RD0   = 33'h1 << 22, S_CY_CAP   = 33'h1 << 23,
        S_CY_STEP  = 33'h1 << 24, S_CY_XCH   = 33'h1 << 25, S_CY_NEXT  = 33'h1 << 26,
        S_SH_ADV   = 33'h1 << 27, S_FREV     = 33'h1 << 28, S_EM_INIT  = 33'h1 << 29,
        S_EM_RD    = 33'h1 << 30, S_EM_CAP   = 33'h1 << 31, S_EM_WAIT  = 33'h1 << 32
    } state_t;

    state_t state_reg, state_next;
    state_t swret_reg, swret_next;
    state_t rvret_reg, rvret_next;

    always_comb begin
        state_next = state_reg;
        swret_next = swret_reg;
        rvret_next = rvret_reg;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            S_LOAD: begin
                if (s_valid) begin
                    cmd.op = OP_LOAD;
                    if (s_last) begin
                        state_next = S_SEL_INIT;
                    end
                end
            end
            S_SEL_INIT: begin
                cmd.op     = OP_SEL_INIT;
                state_next = S_SEL_CHK;
            end
            S_SEL_CHK:  state_next = stat.sel_live ? S_PIV_RD : S_SH_INIT;
            S_PIV_RD: begin
                cmd.op     = OP_PIV_RD;
                state_next = S_PIV_CAP;
            end
            S_PIV_CAP: begin
                cmd.op     = OP_PIV_CAP;
                state_next = S_PART;
            end
            S_PART: begin
                if (stat.part_done) begin
                    state_next = S_NARROW;
                end else begin
                    cmd.op     = OP_V_RD;
                    state_next = S_V_DEC;
                end
            end
            S_V_DEC: begin
                priority if (stat.v_eq) begin
                    cmd.op     = OP_EQ_STEP;
                    state_next = S_PART;
                end else if (stat.v_lt) begin
                    cmd.op     = OP_LT_SET;
                    swret_next = S_LT_POST;
                    state_next = S_SW_RA;
                end else begin
                    cmd.op     = OP_GT_SET;
                    swret_next = S_GT_POST;
                    state_next = S_SW_RA;
                end
            end
            S_LT_POST: begin
                cmd.op     = OP_LT_POST;
                state_next = S_PART;
            end
            S_GT_POST: begin
                cmd.op     = OP_GT_POST;
                state_next = S_PART;
            end
            S_NARROW: begin
                if (stat.sel_hit) begin
                    state_next = S_SH_INIT;
                end else begin
                    cmd.op     = OP_NARROW;
                    state_next = S_SEL_CHK;
                end
            end
            S_SW_RA: begin
                cmd.op     = OP_SW_RA;
                state_next = S_SW_RB;
            end
            S_SW_RB: begin
                cmd.op     = OP_SW_RB;
                state_next = S_SW_WA;
            end
            S_SW_WA: begin
                cmd.op     = OP_SW_WA;
                state_next = S_SW_WB;
            end
            S_SW_WB: begin
                cmd.op     = OP_SW_WB;
                state_next = swret_reg;
            end
            S_REV: begin
                if (stat.rev_live) begin
                    swret_next = S_REV_STEP;
                    state_next = S_SW_RA;
                end else begin
                    state_next = rvret_reg;
                end
            end
            S_REV_STEP: begin
                cmd.op     = OP_REV_STEP;
                state_next = S_REV;
            end
            S_SH_INIT: begin
                cmd.op     = OP_SH_INIT;
                state_next = S_SH_SIZE;
            end
            S_SH_SIZE: begin
                if (stat.size_more) begin
                    cmd.op = OP_PW_INC;
                end else begin
                    state_next = S_SH_LOOP;
                end
            end
            S_SH_LOOP: begin
                priority if (!stat.sh_live) begin
                    state_next = stat.even ? S_FREV : S_EM_INIT;
                end else if (stat.split_fit) begin
                    cmd.op     = OP_REV1_SET;
                    rvret_next = S_REV2;
                    state_next = S_REV;
                end else begin
                    cmd.op = OP_PW_DEC;
                end
            end
            S_REV2: begin
                cmd.op     = OP_REV2_SET;
                rvret_next = S_REV3;
                state_next = S_REV;
            end
            S_REV3: begin
                cmd.op     = OP_REV3_SET;
                rvret_next = S_CY_INIT;
                state_next = S_REV;
            end
            S_CY_INIT: begin
                cmd.op     = OP_CY_INIT;
                state_next = S_CY_RD0;
            end
            S_CY_RD0: begin
                cmd.op     = OP_CY_RD0;
                state_next = S_CY_CAP;
            end
            S_CY_CAP: begin
                cmd.op     = OP_CY_CAP;
                state_next = S_CY_STEP;
            end
            S_CY_STEP: begin
                if (stat.cy_closed) begin
                    cmd.op     = OP_CY_CLOSE;
                    state_next = S_CY_NEXT;
                end else begin
                    cmd.op     = OP_CY_RD;
                    state_next = S_CY_XCH;
                end
            end
            S_CY_XCH: begin
                cmd.op     = OP_CY_XCH;
                state_next = S_CY_STEP;
            end
            S_CY_NEXT:  state_next = stat.cy_more ? S_CY_RD0 : S_SH_ADV;
            S_SH_ADV: begin
                cmd.op     = OP_SH_ADV;
                state_next = S_SH_LOOP;
            end
            S_FREV: begin
                cmd.op     = OP_FREV_SET;
                rvret_next = S_EM_INIT;
                state_next = S_REV;
            end
            S_EM_INIT: begin
                cmd.op     = OP_EM_INIT;
                state_next = S_EM_RD;
            end
            S_EM_RD: begin
                cmd.op     = OP_EM_RD;
                state_next = S_EM_CAP;
            end
            S_EM_CAP: begin
                cmd.op     = OP_EM_CAP;
                state_next = S_EM_WAIT;
            end
            S_EM_WAIT: begin
                if (m_ready) begin
                    if (stat.em_last) begin
                        cmd.op     = OP_EM_DONE;
                        state_next = S_LOAD;
                    end else begin
                        cmd.op     = OP_EM_NEXT;
                        state_next = S_EM_RD;
                    end
                end
            end
            default:    state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
            swret_reg <= S_LOAD;
            rvret_reg <= S_LOAD;
        end else begin
            state_reg <= state_next;
            swret_reg <= swret_next;
            rvret_reg <= rvret_next;
        end
    end

    assign s_ready = state_reg == S_LOAD;

endmodule

>>> rtl/core/wiggle_sort_median_shuffle.sv
// ----------------------------------------------------------------------------
// wiggle_sort_median_shuffle: wiggle ordering by median select and shuffle
// Collects a set of signed values, reorders it so that small and large
// values alternate, and streams the result back out.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one signed 32-bit value per request; s_last closes the set.
//     Requests past MAX_N are dropped and flag m_overflowed on every result.
//   m_ channel: one request per stored value in index order; m_final_res
//     marks the last one. s_ready is low from s_last until the last result
//     has been taken.
//   Rate: one request per cycle while loading. After s_last the set is
//     worked on in place in the value store, which has one read and one
//     write port: quickselect for rank n/2 (an element equal to the
//     pivot is stepped past, any other needs a swap, and a swap reads both
//     entries and then writes both back), then the cycle-leader shuffle
//     with its block reversals, then emit, which reads, captures and
//     waits for m_ready for each result.
//   Reset: synchronous, active low; clears the count, the overflow flag
//     and the output valid. The store itself is not cleared.
//   Stall: a low m_ready simply freezes the sequencer in its emit wait.
// ----------------------------------------------------------------------------
module wiggle_sort_median_shuffle import wsms_pkg::*; #(
    parameter int MAX_N            = 64,
    parameter int POW3_TABLE_DEPTH = 20
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [DATA_W-1:0] s_value,
    input  logic                     s_last,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_result_value,
    output logic                     m_final_res,
    output logic                     m_overflowed
);

    wsms_cmd_t  cmd;
    wsms_stat_t stat;

    // sequencer: owns the state machine and the swap/reverse return points
    wsms_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_last),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd),
        .s_ready (s_ready)
    );

    // datapath: value store, index registers and output register
    wsms_datapath #(
        .MAX_N            (MAX_N),
        .POW3_TABLE_DEPTH (POW3_TABLE_DEPTH)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .s_value        (s_value),
        .stat           (stat),
        .m_result_value (m_result_value),
        .m_final_res    (m_final_res),
        .m_overflowed   (m_overflowed),
        .m_valid        (m_valid)
    );

`ifndef SYNTHESIS
    // loading and emitting never overlap
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while a result is pending");

    // after the final result is taken the block is back to loading
    a_back_to_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_final_res) |=> (s_ready && !m_valid))
        else $error("block not back to load after final result");

    // reset leaves no result pending
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");
`endif

endmodule
